[hdl/isse_pkg.sv]
package isse_pkg;

   localparam int KEY_BITS   = 16;
   localparam int UNIV_BITS  = 17;
   localparam int WORD_BITS  = 64;
   localparam int BIT_BITS   = 6;
   localparam int WIDX_BITS  = 10;
   localparam int NUM_WORDS  = 1024;
   localparam int SUM_WORDS  = 16;
   localparam int SIDX_BITS  = 4;

   localparam logic [UNIV_BITS-1:0] UNIV_MIN   = 17'd2;
   localparam logic [UNIV_BITS-1:0] UNIV_MAX   = 17'd65536;
   localparam logic [UNIV_BITS-1:0] UNIV_RESET = 17'd65536;
   localparam logic [UNIV_BITS-1:0] KEY_TOP    = 17'd65535;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_MEMBER = 3'd2;
   localparam logic [2:0] OP_MIN    = 3'd3;
   localparam logic [2:0] OP_MAX    = 3'd4;
   localparam logic [2:0] OP_SUCC   = 3'd5;
   localparam logic [2:0] OP_PRED   = 3'd6;
   localparam logic [2:0] OP_NOP    = 3'd7;

   typedef struct packed {
      logic [2:0]          opcode;
      logic [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic [KEY_BITS-1:0] value;
      logic                range_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_WORD,
      ST_SRCH_A,
      ST_SRCH_B,
      ST_SRCH_C
   } state_type;

   typedef enum logic [1:0] {
      PURP_QUERY,
      PURP_DEL_MIN,
      PURP_DEL_MAX
   } purp_type;

   typedef enum logic [1:0] {
      P_SUCC,
      P_PRED,
      P_ZERO,
      P_TOP
   } psel_type;

   typedef enum logic [1:0] {
      RSP_IMM,
      RSP_WORD,
      RSP_SRCH,
      RSP_DEL
   } rkind_type;

   typedef struct packed {
      logic      cfg_wr;
      logic      clr_step;
      logic      load_req;
      logic      word_rd;
      logic      word_upd;
      logic      srch_load;
      psel_type  p_sel;
      logic      srch_a;
      logic      srch_b;
      logic      srch_c;
      logic      set_min;
      logic      set_max;
      logic      set_empty;
      logic      respond;
      rkind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       rerr;
      logic       member;
      logic       srch_stop;
      logic       srch_found;
      logic       clr_last;
   } stat_type;

   function automatic logic [BIT_BITS-1:0] low_bit64(input logic [WORD_BITS-1:0] v);
      logic [BIT_BITS-1:0] n;
      n = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            n = BIT_BITS'(i);
         end
      end
      return n;
   endfunction

   function automatic logic [BIT_BITS-1:0] high_bit64(input logic [WORD_BITS-1:0] v);
      logic [BIT_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (v[i]) begin
            n = BIT_BITS'(i);
         end
      end
      return n;
   endfunction

   function automatic logic [SIDX_BITS-1:0] low_bit16(input logic [SUM_WORDS-1:0] v);
      logic [SIDX_BITS-1:0] n;
      n = '0;
      for (int i = SUM_WORDS - 1; i >= 0; i--) begin
         if (v[i]) begin
            n = SIDX_BITS'(i);
         end
      end
      return n;
   endfunction

   function automatic logic [SIDX_BITS-1:0] high_bit16(input logic [SUM_WORDS-1:0] v);
      logic [SIDX_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < SUM_WORDS; i++) begin
         if (v[i]) begin
            n = SIDX_BITS'(i);
         end
      end
      return n;
   endfunction

endpackage

[hdl/integer_set_successor_engine_unit.sv]
// Integer set engine over keys 0 to 65535 with insert, delete, member, minimum, maximum,
// strict successor and strict predecessor. A command beat is taken on a clock edge where
// start is high and busy is low; its one result beat appears on rsp_payload for exactly
// one cycle with rsp_strobe high, and the receiver cannot stall it, so it must capture
// every strobed beat. Minimum, maximum, out-of-range keys and opcode seven are answered
// without a bitmap read; member, insert and a delete of an absent key read one bitmap
// word; successor and predecessor run one search; a delete of a present key runs two
// searches for the new minimum and maximum, or only the first when it removes the last key.
// The bitmap memory has one read port: a search reads
// the start word and, when that word has no match, a second word found through the
// summary bits. After reset and after every write of universe_size the bitmap is cleared
// one word per cycle over all 1024 words, during which busy stays high; configuration writes
// are still taken then and restart the pass. While idle, a configuration write waits
// as long as start is high.
module integer_set_successor_engine_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  isse_pkg::req_type              req_payload,
   output logic                           rsp_strobe,
   output isse_pkg::rsp_type              rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [isse_pkg::UNIV_BITS-1:0] csr_data
);

   isse_pkg::cmd_type  cmd;
   isse_pkg::stat_type stat;

   // The controller sequences each command; the datapath holds the bitmap, the summary
   // bits, the min and max registers and the search logic.
   isse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .busy      (busy),
      .stat      (stat),
      .cmd       (cmd)
   );

   isse_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

[hdl/isse_ctrl.sv]
module isse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               csr_valid,
   output logic               csr_ready,
   output logic               busy,
   input  isse_pkg::stat_type stat,
   output isse_pkg::cmd_type  cmd
);

   isse_pkg::state_type state_ff, state_in;
   isse_pkg::purp_type  purp_ff, purp_in;
   logic                cfg_wr;
   logic                imm_op;
   logic                word_op;

   // In idle a register write waits while start is high, so a command beat and a
   // write never share an edge.
   assign csr_ready = ((state_ff == isse_pkg::ST_IDLE) && !start) ||
                      (state_ff == isse_pkg::ST_CLEAR);
   assign cfg_wr    = csr_valid && csr_ready;
   assign busy      = (state_ff != isse_pkg::ST_IDLE);

   assign imm_op  = stat.rerr || (stat.op == isse_pkg::OP_MIN) ||
                    (stat.op == isse_pkg::OP_MAX) || (stat.op == isse_pkg::OP_NOP);
   assign word_op = (stat.op == isse_pkg::OP_INSERT) || (stat.op == isse_pkg::OP_DELETE) ||
                    (stat.op == isse_pkg::OP_MEMBER);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isse_pkg::ST_CLEAR;
         purp_ff  <= isse_pkg::PURP_QUERY;
      end else begin
         state_ff <= state_in;
         purp_ff  <= purp_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      purp_in  = purp_ff;
      case (state_ff)
         isse_pkg::ST_CLEAR: begin
            if (!cfg_wr && stat.clr_last) begin
               state_in = isse_pkg::ST_IDLE;
            end
         end
         isse_pkg::ST_IDLE: begin
            if (cfg_wr) begin
               state_in = isse_pkg::ST_CLEAR;
            end else if (start) begin
               state_in = isse_pkg::ST_DECODE;
            end
         end
         isse_pkg::ST_DECODE: begin
            if (imm_op) begin
               state_in = isse_pkg::ST_IDLE;
            end else if (word_op) begin
               state_in = isse_pkg::ST_WORD;
            end else begin
               purp_in  = isse_pkg::PURP_QUERY;
               state_in = isse_pkg::ST_SRCH_A;
            end
         end
         isse_pkg::ST_WORD: begin
            if (stat.op == isse_pkg::OP_DELETE && stat.member) begin
               purp_in  = isse_pkg::PURP_DEL_MIN;
               state_in = isse_pkg::ST_SRCH_A;
            end else begin
               state_in = isse_pkg::ST_IDLE;
            end
         end
         isse_pkg::ST_SRCH_A: begin
            state_in = isse_pkg::ST_SRCH_B;
         end
         isse_pkg::ST_SRCH_B, isse_pkg::ST_SRCH_C: begin
            if (state_ff == isse_pkg::ST_SRCH_B && !stat.srch_stop) begin
               state_in = isse_pkg::ST_SRCH_C;
            end else if (purp_ff == isse_pkg::PURP_DEL_MIN && stat.srch_found) begin
               purp_in  = isse_pkg::PURP_DEL_MAX;
               state_in = isse_pkg::ST_SRCH_A;
            end else begin
               state_in = isse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = isse_pkg::ST_CLEAR;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd        = '0;
      cmd.cfg_wr = cfg_wr;
      case (state_ff)
         isse_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         isse_pkg::ST_IDLE: begin
            cmd.load_req = start && !cfg_wr;
         end
         isse_pkg::ST_DECODE: begin
            if (imm_op) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = isse_pkg::RSP_IMM;
            end else if (word_op) begin
               cmd.word_rd = 1'b1;
            end else begin
               cmd.srch_load = 1'b1;
               cmd.p_sel     = (stat.op == isse_pkg::OP_SUCC) ? isse_pkg::P_SUCC
                                                               : isse_pkg::P_PRED;
            end
         end
         isse_pkg::ST_WORD: begin
            cmd.word_upd = 1'b1;
            if (stat.op == isse_pkg::OP_DELETE && stat.member) begin
               cmd.srch_load = 1'b1;
               cmd.p_sel     = isse_pkg::P_ZERO;
            end else begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = isse_pkg::RSP_WORD;
            end
         end
         isse_pkg::ST_SRCH_A: begin
            cmd.srch_a = 1'b1;
         end
         isse_pkg::ST_SRCH_B, isse_pkg::ST_SRCH_C: begin
            cmd.srch_b = (state_ff == isse_pkg::ST_SRCH_B);
            cmd.srch_c = (state_ff == isse_pkg::ST_SRCH_C);
            if (state_ff == isse_pkg::ST_SRCH_C || stat.srch_stop) begin
               case (purp_ff)
                  isse_pkg::PURP_DEL_MIN: begin
                     if (stat.srch_found) begin
                        cmd.set_min   = 1'b1;
                        cmd.srch_load = 1'b1;
                        cmd.p_sel     = isse_pkg::P_TOP;
                     end else begin
                        cmd.set_empty = 1'b1;
                        cmd.respond   = 1'b1;
                        cmd.rsp_kind  = isse_pkg::RSP_DEL;
                     end
                  end
                  isse_pkg::PURP_DEL_MAX: begin
                     cmd.set_max  = 1'b1;
                     cmd.respond  = 1'b1;
                     cmd.rsp_kind = isse_pkg::RSP_DEL;
                  end
                  default: begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_kind = isse_pkg::RSP_SRCH;
                  end
               endcase
            end
         end
         default: begin
            cmd.clr_step = 1'b0;
         end
      endcase
   end

endmodule

[hdl/isse_dp.sv]
module isse_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  isse_pkg::req_type                  req_payload,
   input  logic [isse_pkg::UNIV_BITS-1:0]     csr_data,
   input  isse_pkg::cmd_type                  cmd,
   output isse_pkg::stat_type                 stat,
   output logic                               rsp_strobe,
   output isse_pkg::rsp_type                  rsp_payload
);

   // Membership bitmap: one bit per key, in 64-bit words.
   logic [isse_pkg::WORD_BITS-1:0] mem [isse_pkg::NUM_WORDS];
   logic [isse_pkg::WORD_BITS-1:0] rdata_ff;
   logic [isse_pkg::WIDX_BITS-1:0] rd_addr, wr_addr;
   logic [isse_pkg::WORD_BITS-1:0] wr_data;
   logic                           wr_en;

   // Summary: one bit per nonempty word, and one bit per nonempty summary word.
   logic [isse_pkg::WORD_BITS-1:0] summary_ff [isse_pkg::SUM_WORDS];
   logic [isse_pkg::SUM_WORDS-1:0] sum2_ff;
   logic [isse_pkg::SIDX_BITS-1:0] sum_addr;
   logic [isse_pkg::WORD_BITS-1:0] sum_rd;

   logic [isse_pkg::UNIV_BITS-1:0] universe_ff;
   logic [isse_pkg::UNIV_BITS-1:0] univ_act;
   isse_pkg::req_type              req_ff;
   logic [isse_pkg::KEY_BITS-1:0]  min_ff, max_ff;
   logic                           nonempty_ff;
   logic [isse_pkg::WIDX_BITS-1:0] clr_cnt_ff;
   logic                           rsp_strobe_ff;
   isse_pkg::rsp_type              rsp_ff;

   // Search registers.
   logic [isse_pkg::UNIV_BITS-1:0] p_ff;
   logic                           next_ff;
   logic [isse_pkg::WORD_BITS-1:0] wmask_ff;
   logic [isse_pkg::WIDX_BITS-1:0] w_ff;
   logic                           wvalid_ff;
   logic                           edge_ff;
   logic                           cand1_ok_ff;
   logic [isse_pkg::WIDX_BITS-1:0] cand1_idx_ff;
   logic                           s2_ok_ff;
   logic [isse_pkg::SIDX_BITS-1:0] s2_ff;
   logic [isse_pkg::WIDX_BITS-1:0] idx_ff;

   logic [isse_pkg::UNIV_BITS-1:0] p_new;
   logic                           next_new;
   logic [isse_pkg::WIDX_BITS-1:0] a_w, a_sw;
   logic [isse_pkg::BIT_BITS-1:0]  a_b;
   logic [isse_pkg::WORD_BITS-1:0] a_wmask, a_smask, a_sbits;
   logic [isse_pkg::SUM_WORDS-1:0] a_s2bits;
   logic                           a_edge;
   logic [isse_pkg::BIT_BITS-1:0]  a_slo;
   logic [isse_pkg::WORD_BITS-1:0] b_masked;
   logic                           b_hit, b_cand_ok;
   logic [isse_pkg::WIDX_BITS-1:0] b_idx;
   logic [isse_pkg::BIT_BITS-1:0]  b_enc, c_enc, s2_enc;
   logic [isse_pkg::KEY_BITS-1:0]  srch_value;
   logic                           srch_found;

   logic                           uses_key, rerr, member;
   logic [isse_pkg::WIDX_BITS-1:0] kw;
   logic [isse_pkg::WORD_BITS-1:0] kbit, sbit, ins_word, del_word, del_sum;
   logic                           do_ins, do_del;
   logic [isse_pkg::KEY_BITS-1:0]  imm_value;
   logic                           imm_hit;

   // Request decode and range check.
   always_comb begin
      if (universe_ff < isse_pkg::UNIV_MIN) begin
         univ_act = isse_pkg::UNIV_MIN;
      end else if (universe_ff > isse_pkg::UNIV_MAX) begin
         univ_act = isse_pkg::UNIV_MAX;
      end else begin
         univ_act = universe_ff;
      end
   end

   assign uses_key = (req_ff.opcode == isse_pkg::OP_INSERT) ||
                     (req_ff.opcode == isse_pkg::OP_DELETE) ||
                     (req_ff.opcode == isse_pkg::OP_MEMBER) ||
                     (req_ff.opcode == isse_pkg::OP_SUCC) ||
                     (req_ff.opcode == isse_pkg::OP_PRED);
   assign rerr     = uses_key && ({1'b0, req_ff.key} >= univ_act);

   assign kw       = req_ff.key[isse_pkg::KEY_BITS-1:isse_pkg::BIT_BITS];
   assign kbit     = {{(isse_pkg::WORD_BITS-1){1'b0}}, 1'b1} << req_ff.key[isse_pkg::BIT_BITS-1:0];
   assign sbit     = {{(isse_pkg::WORD_BITS-1){1'b0}}, 1'b1} << kw[isse_pkg::BIT_BITS-1:0];
   assign member   = |(rdata_ff & kbit);
   assign ins_word = rdata_ff | kbit;
   assign del_word = rdata_ff & ~kbit;
   assign del_sum  = sum_rd & ~sbit;
   assign do_ins   = cmd.word_upd && (req_ff.opcode == isse_pkg::OP_INSERT) && !member;
   assign do_del   = cmd.word_upd && (req_ff.opcode == isse_pkg::OP_DELETE) && member;

   // Search start point.
   always_comb begin
      case (cmd.p_sel)
         isse_pkg::P_SUCC: begin
            p_new    = {1'b0, req_ff.key} + 17'd1;
            next_new = 1'b1;
         end
         isse_pkg::P_PRED: begin
            p_new    = {1'b0, req_ff.key} - 17'd1;
            next_new = 1'b0;
         end
         isse_pkg::P_ZERO: begin
            p_new    = '0;
            next_new = 1'b1;
         end
         default: begin
            p_new    = isse_pkg::KEY_TOP;
            next_new = 1'b0;
         end
      endcase
   end

   // First search step: mask for the start word, and the summary candidates.
   assign a_w     = p_ff[isse_pkg::KEY_BITS-1:isse_pkg::BIT_BITS];
   assign a_b     = p_ff[isse_pkg::BIT_BITS-1:0];
   assign a_sw    = next_ff ? (a_w + 10'd1) : (a_w - 10'd1);
   assign a_wmask = next_ff ? ({isse_pkg::WORD_BITS{1'b1}} << a_b)
                            : ({isse_pkg::WORD_BITS{1'b1}} >> (6'd63 - a_b));
   assign a_smask = next_ff ? ({isse_pkg::WORD_BITS{1'b1}} << a_sw[isse_pkg::BIT_BITS-1:0])
                            : ({isse_pkg::WORD_BITS{1'b1}} >>
                               (6'd63 - a_sw[isse_pkg::BIT_BITS-1:0]));
   assign a_sbits = sum_rd & a_smask;
   assign a_slo   = next_ff ? isse_pkg::low_bit64(a_sbits) : isse_pkg::high_bit64(a_sbits);
   assign a_s2bits = next_ff
      ? (sum2_ff & ((16'hFFFF << a_sw[isse_pkg::WIDX_BITS-1:isse_pkg::BIT_BITS]) << 1))
      : (sum2_ff & ~(16'hFFFF << a_sw[isse_pkg::WIDX_BITS-1:isse_pkg::BIT_BITS]));
   assign a_edge  = p_ff[isse_pkg::UNIV_BITS-1] ||
                    (next_ff ? (a_w == 10'd1023) : (a_w == 10'd0));

   // Second and third search steps.
   assign b_masked  = rdata_ff & wmask_ff;
   assign b_hit     = wvalid_ff && (|b_masked);
   assign b_enc     = next_ff ? isse_pkg::low_bit64(b_masked) : isse_pkg::high_bit64(b_masked);
   assign s2_enc    = next_ff ? isse_pkg::low_bit64(sum_rd) : isse_pkg::high_bit64(sum_rd);
   assign b_idx     = cand1_ok_ff ? cand1_idx_ff : {s2_ff, s2_enc};
   assign b_cand_ok = !edge_ff && (cand1_ok_ff || s2_ok_ff);
   assign c_enc     = next_ff ? isse_pkg::low_bit64(rdata_ff) : isse_pkg::high_bit64(rdata_ff);
   assign srch_value = cmd.srch_c ? {idx_ff, c_enc} : {w_ff, b_enc};
   assign srch_found = cmd.srch_c || b_hit;

   // Summary read address.
   always_comb begin
      if (cmd.srch_a) begin
         sum_addr = a_sw[isse_pkg::WIDX_BITS-1:isse_pkg::BIT_BITS];
      end else if (cmd.srch_b) begin
         sum_addr = s2_ff;
      end else begin
         sum_addr = kw[isse_pkg::WIDX_BITS-1:isse_pkg::BIT_BITS];
      end
   end
   assign sum_rd = summary_ff[sum_addr];

   // Bitmap ports.
   always_comb begin
      if (cmd.srch_a) begin
         rd_addr = a_w;
      end else if (cmd.srch_b) begin
         rd_addr = b_idx;
      end else begin
         rd_addr = kw;
      end
      wr_en   = cmd.clr_step || do_ins || do_del;
      wr_addr = cmd.clr_step ? clr_cnt_ff : kw;
      if (cmd.clr_step) begin
         wr_data = '0;
      end else if (do_ins) begin
         wr_data = ins_word;
      end else begin
         wr_data = del_word;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Search registers.
   always_ff @(posedge clock) begin
      if (cmd.srch_load) begin
         p_ff    <= p_new;
         next_ff <= next_new;
      end
      if (cmd.srch_a) begin
         wmask_ff     <= a_wmask;
         w_ff         <= a_w;
         wvalid_ff    <= !p_ff[isse_pkg::UNIV_BITS-1];
         edge_ff      <= a_edge;
         cand1_ok_ff  <= |a_sbits;
         cand1_idx_ff <= {a_sw[isse_pkg::WIDX_BITS-1:isse_pkg::BIT_BITS], a_slo};
         s2_ok_ff     <= |a_s2bits;
         s2_ff        <= next_ff ? isse_pkg::low_bit16(a_s2bits)
                                 : isse_pkg::high_bit16(a_s2bits);
      end
      if (cmd.srch_b) begin
         idx_ff <= b_idx;
      end
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
   end

   // Set state, configuration and clearing pass.
   always_ff @(posedge clock) begin
      if (reset || cmd.cfg_wr) begin
         for (int i = 0; i < isse_pkg::SUM_WORDS; i++) begin
            summary_ff[i] <= '0;
         end
         sum2_ff     <= '0;
         min_ff      <= '0;
         max_ff      <= '0;
         nonempty_ff <= 1'b0;
         clr_cnt_ff  <= '0;
         universe_ff <= reset ? isse_pkg::UNIV_RESET : csr_data;
      end else begin
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + 10'd1;
         end
         if (do_ins) begin
            summary_ff[sum_addr] <= sum_rd | sbit;
            sum2_ff[sum_addr]    <= 1'b1;
            if (!nonempty_ff) begin
               min_ff      <= req_ff.key;
               max_ff      <= req_ff.key;
               nonempty_ff <= 1'b1;
            end else begin
               if (req_ff.key < min_ff) begin
                  min_ff <= req_ff.key;
               end
               if (req_ff.key > max_ff) begin
                  max_ff <= req_ff.key;
               end
            end
         end
         if (do_del && (del_word == '0)) begin
            summary_ff[sum_addr] <= del_sum;
            sum2_ff[sum_addr]    <= |del_sum;
         end
         if (cmd.set_min) begin
            min_ff <= srch_value;
         end
         if (cmd.set_max) begin
            max_ff <= srch_value;
         end
         if (cmd.set_empty) begin
            min_ff      <= '0;
            max_ff      <= '0;
            nonempty_ff <= 1'b0;
         end
      end
   end

   // Result register.
   always_comb begin
      imm_hit   = 1'b0;
      imm_value = '0;
      if (!rerr && nonempty_ff) begin
         if (req_ff.opcode == isse_pkg::OP_MIN) begin
            imm_hit   = 1'b1;
            imm_value = min_ff;
         end else if (req_ff.opcode == isse_pkg::OP_MAX) begin
            imm_hit   = 1'b1;
            imm_value = max_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         case (cmd.rsp_kind)
            isse_pkg::RSP_IMM: begin
               rsp_ff.hit         <= imm_hit;
               rsp_ff.value       <= imm_value;
               rsp_ff.range_error <= rerr;
            end
            isse_pkg::RSP_WORD: begin
               rsp_ff.hit         <= (req_ff.opcode == isse_pkg::OP_INSERT) ? !member : member;
               rsp_ff.value       <= '0;
               rsp_ff.range_error <= 1'b0;
            end
            isse_pkg::RSP_SRCH: begin
               rsp_ff.hit         <= srch_found;
               rsp_ff.value       <= srch_found ? srch_value : '0;
               rsp_ff.range_error <= 1'b0;
            end
            default: begin
               rsp_ff.hit         <= 1'b1;
               rsp_ff.value       <= '0;
               rsp_ff.range_error <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   assign stat.op         = req_ff.opcode;
   assign stat.rerr       = rerr;
   assign stat.member     = member;
   assign stat.srch_stop  = b_hit || !b_cand_ok;
   assign stat.srch_found = srch_found;
   assign stat.clr_last   = (clr_cnt_ff == 10'd1023);

endmodule
